// ===== design/apba_pkg.sv =====
// Shared types and constants for the aligned power-of-two block allocator.
package apba_pkg;

  localparam int NUM_CELLS = 64;

  localparam logic [31:0] POOL_CAP = 32'h8000_0000;
  localparam logic [31:0] POOL_RESET = 32'd1048576;

  // register indexes, from paddr[2]
  localparam logic REG_POOL = 1'b0;
  localparam logic REG_BASE = 1'b1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef enum logic [1:0] {
    TOK_SEARCH,
    TOK_COMMIT,
    TOK_FREE
  } tok_kind_t;

  // token that walks down the cell chain
  typedef struct packed {
    logic        vld;
    tok_kind_t   kind;
    logic [32:0] cand;       // candidate offset
    logic [4:0]  lg;         // log2 of block size
    logic [31:0] addr;       // address to free
    logic        flag;       // search: bumped; commit: written; free: found
    logic        free_seen;  // search: an empty entry was passed
  } tok_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SIZE,
    S_LAUNCH,
    S_WAIT,
    S_OUT
  } state_t;

endpackage

// ===== design/apba_if.sv =====
// Word channels for allocator commands and responses.
interface apba_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [30:0] req_size;
  logic [31:0] free_address;
  modport source (output valid, cmd, req_size, free_address, input ready);
  modport sink (input valid, cmd, req_size, free_address, output ready);
endinterface

interface apba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] block_address;
  modport source (output valid, status, block_address, input ready);
  modport sink (input valid, status, block_address, output ready);
endinterface

// ===== design/aligned_pow2_block_allocator.sv =====
// Top level of the aligned power-of-two block allocator.
//
// Command words arrive on req (valid/ready): cmd 0 allocates req_size bytes,
// rounded up to a power of two; cmd 1 frees the block holding free_address.
// Each command gives one response word on rsp: status and, for a successful
// allocate, the block address (base_address + offset).
// The table is a chain of 64 cells, one entry each. A token walks the chain,
// one cell per cycle; each command makes one or more passes:
//   free      one pass, first matching entry clears itself
//   allocate  size rounding, then search passes until one goes through
//             without bumping the candidate, then one commit pass where
//             the lowest empty entry takes the block.
// Commands are handled one at a time.
// req is taken again as soon as the previous result sits in the rsp register,
// even if the receiver has not taken it yet; a stalled rsp holds its word and
// the next result waits inside until the register frees.
// Reset empties the table at once (valid bits), loads pool_bytes = 1 MiB and
// base_address = 0, and leaves the chain and rsp empty.
// Config over APB: reg 0 pool_bytes at 0x0, reg 1 base_address at 0x4.
module aligned_pow2_block_allocator import apba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  apba_req_if.sink    req,
  apba_rsp_if.source  rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] pool_bytes;
  logic [30:0] base_address;

  apba_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pool_bytes, .base_address
  );

  // chain of cells
  tok_t tok [NUM_CELLS+1];
  logic [NUM_CELLS-1:0] tok_vld_vec;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    apba_cell u_cell (
      .clk, .rst, .base_address,
      .tok_in(tok[i]),
      .tok_out(tok[i+1])
    );
    assign tok_vld_vec[i] = tok[i+1].vld;
  end

  // controller
  state_t      state, state_next;
  logic        cmd, cmd_next;
  logic [30:0] req_size;
  logic [31:0] free_addr;
  logic [4:0]  lg, lg_next;
  logic [32:0] cand, cand_next;
  logic        first, first_next;
  tok_kind_t   kind, kind_next;
  logic [1:0]  res_st, res_st_next;
  logic [31:0] res_addr, res_addr_next;
  logic        rsp_valid;
  logic [1:0]  rsp_status;
  logic [31:0] rsp_addr;

  logic [31:0] lim, sz32;
  logic [33:0] cand_end;
  logic        launch, out_free;
  tok_t        last;

  assign lim = (pool_bytes > POOL_CAP) ? POOL_CAP : pool_bytes;
  assign sz32 = 32'(1) << lg;
  assign cand_end = {1'b0, cand} + {2'b0, sz32};
  assign last = tok[NUM_CELLS];
  assign out_free = !rsp_valid || rsp.ready;
  assign req.ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd_next = cmd;
    lg_next = lg;
    cand_next = cand;
    first_next = first;
    kind_next = kind;
    res_st_next = res_st;
    res_addr_next = res_addr;
    launch = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          cmd_next = req.cmd;
          lg_next = '0;
          cand_next = '0;
          first_next = 1'b1;
          res_addr_next = '0;
          if (req.cmd == CMD_FREE) begin
            kind_next = TOK_FREE;
            state_next = S_LAUNCH;
          end else begin
            kind_next = TOK_SEARCH;
            state_next = S_SIZE;
          end
        end
      end
      S_SIZE: begin
        if (lg < 5'd31 && sz32 < {1'b0, req_size}) begin
          lg_next = lg + 5'd1;
        end else if (sz32 > lim) begin
          res_st_next = ST_NO_SPACE;
          state_next = S_OUT;
        end else begin
          state_next = S_LAUNCH;
        end
      end
      S_LAUNCH: begin
        if (kind == TOK_SEARCH && cand_end > {2'b0, lim}) begin
          res_st_next = ST_NO_SPACE;
          state_next = S_OUT;
        end else begin
          launch = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        if (last.vld) begin
          case (kind)
            TOK_SEARCH: begin
              if (first && !last.free_seen) begin
                res_st_next = ST_FULL;
                state_next = S_OUT;
              end else if (last.flag) begin
                cand_next = last.cand;
                first_next = 1'b0;
                state_next = S_LAUNCH;
              end else begin
                kind_next = TOK_COMMIT;
                state_next = S_LAUNCH;
              end
            end
            TOK_COMMIT: begin
              res_st_next = ST_OK;
              res_addr_next = {1'b0, base_address} + cand[31:0];
              state_next = S_OUT;
            end
            default: begin
              res_st_next = last.flag ? ST_OK : ST_NOT_FOUND;
              state_next = S_OUT;
            end
          endcase
        end
      end
      S_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    tok[0].vld = launch;
    tok[0].kind = kind;
    tok[0].cand = cand;
    tok[0].lg = lg;
    tok[0].addr = free_addr;
    tok[0].flag = 1'b0;
    tok[0].free_seen = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
    cmd <= cmd_next;
    lg <= lg_next;
    cand <= cand_next;
    first <= first_next;
    kind <= kind_next;
    res_st <= res_st_next;
    res_addr <= res_addr_next;
    if (state == S_IDLE && req.valid) begin
      req_size <= req.req_size;
      free_addr <= req.free_address;
    end
    if (state == S_OUT && out_free) begin
      rsp_status <= res_st;
      rsp_addr <= (cmd == CMD_ALLOC && res_st == ST_OK) ? res_addr : '0;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.block_address = rsp_addr;

  // at most one token walks the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vld_vec))
    else $error("more than one token in cell chain");

  // chain is empty whenever a new command can be taken
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (tok_vld_vec == '0 && !last.vld))
    else $error("token in chain while idle");

  // a launch always follows from the launch state
  a_launch: assert property (@(posedge clk) disable iff (rst)
    tok[1].vld |-> $past(state) == S_LAUNCH)
    else $error("token entered chain outside launch");

endmodule

// ===== design/apba_regs.sv =====
// APB configuration registers: pool size and base address.
module apba_regs import apba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] pool_bytes,
  output logic [30:0] base_address
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_bytes <= POOL_RESET;
      base_address <= '0;
    end else if (wr) begin
      unique case (paddr[2])
        REG_POOL: pool_bytes <= pwdata;
        REG_BASE: base_address <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_POOL: prdata = pool_bytes;
      REG_BASE: prdata = {1'b0, base_address};
      default: prdata = '0;
    endcase
  end

endmodule

// ===== design/apba_cell.sv =====
// One table entry of the allocator; acts on the token passing through.
module apba_cell import apba_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [30:0] base_address,
  input  tok_t        tok_in,
  output tok_t        tok_out
);

  logic        valid;
  logic [30:0] off;
  logic [4:0]  lg;

  logic [32:0] e_sz, e, sz33, newc, fe;
  logic [33:0] cand_end;
  logic [31:0] s;
  logic        overlap, take, hit;
  tok_t        t;

  always_comb begin
    e_sz = 33'(1) << lg;
    e = {2'b0, off} + e_sz;
    sz33 = 33'(1) << tok_in.lg;
    cand_end = {1'b0, tok_in.cand} + {1'b0, sz33};
    overlap = valid && ({3'b0, off} < cand_end) && (tok_in.cand < e);
    newc = (e + sz33 - 33'(1)) & ~(sz33 - 33'(1));
    s = {1'b0, base_address} + {1'b0, off};
    fe = {1'b0, s} + e_sz;
    take = !valid && !tok_in.flag;
    hit = valid && !tok_in.flag && (tok_in.addr >= s) && ({1'b0, tok_in.addr} < fe);

    t = tok_in;
    case (tok_in.kind)
      TOK_SEARCH: begin
        if (!valid) t.free_seen = 1'b1;
        if (overlap) begin
          t.cand = newc;
          t.flag = 1'b1;
        end
      end
      TOK_COMMIT: if (take) t.flag = 1'b1;
      TOK_FREE:   if (hit) t.flag = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
      if (tok_in.vld && tok_in.kind == TOK_COMMIT && take) valid <= 1'b1;
      if (tok_in.vld && tok_in.kind == TOK_FREE && hit) valid <= 1'b0;
    end
    if (tok_in.vld && tok_in.kind == TOK_COMMIT && take) begin
      off <= tok_in.cand[30:0];
      lg <= tok_in.lg;
    end
    tok_out.kind <= t.kind;
    tok_out.cand <= t.cand;
    tok_out.lg <= t.lg;
    tok_out.addr <= t.addr;
    tok_out.flag <= t.flag;
    tok_out.free_seen <= t.free_seen;
  end

endmodule

// ===== tb/aligned_pow2_block_allocator_test.sv =====
// Self-checking testbench for the aligned power-of-two block allocator.
`timescale 1ns / 100ps

module aligned_pow2_block_allocator_test;
  import apba_pkg::*;

  localparam int          IDLE_LIMIT = 20000;
  localparam int          DRAIN_WAIT = 100;
  localparam longint unsigned CAP = 64'h8000_0000;

  typedef struct {
    bit          is_cfg;   // config write instead of a command word
    logic        sel;      // cmd, or register index for a config row
    logic [31:0] arg;      // size, free address or register value
    bit          chk;      // expected word typed in below
    logic [1:0]  st;
    logic [31:0] ba;
  } stim_row_t;

  typedef struct {
    logic [1:0]  st;
    logic [31:0] ba;
  } rsp_word_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  apba_req_if req_ch ();
  apba_rsp_if rsp_ch ();

  aligned_pow2_block_allocator dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the block table and config registers
  bit          blk_used [NUM_CELLS];
  bit [30:0]   blk_off  [NUM_CELLS];
  bit [4:0]    blk_lg   [NUM_CELLS];
  bit [31:0]   pool_reg;
  bit [30:0]   base_reg;

  rsp_word_t   pending_rsp[$];   // words still owed by the block
  int          errors = 0;
  bit          quiet;            // no idling on either side
  int          idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string what);
    $display("mismatch @%0t: %s", $realtime, what);
    errors++;
  endtask

  // First-fit search over aligned offsets, mirrors the block's decisions
  task automatic predict_alloc(input bit [30:0] req, output rsp_word_t w);
    longint unsigned lim, sz, cand, o, e;
    int lg, slot;
    bit hit;
    w.st = ST_OK;
    w.ba = '0;
    lim = (pool_reg > CAP) ? CAP : pool_reg;
    lg = 0;
    while (lg < 31 && (64'd1 << lg) < req) lg++;
    sz = 64'd1 << lg;
    if (sz > lim) begin
      w.st = ST_NO_SPACE;
      return;
    end
    slot = -1;
    for (int i = 0; i < NUM_CELLS; i++)
      if (!blk_used[i] && slot < 0) slot = i;
    if (slot < 0) begin
      w.st = ST_FULL;
      return;
    end
    cand = 0;
    for (int pass = 0; pass < NUM_CELLS + 2; pass++) begin
      if (cand + sz > lim) begin
        w.st = ST_NO_SPACE;
        return;
      end
      hit = 1'b0;
      for (int i = 0; i < NUM_CELLS && !hit; i++) begin
        if (blk_used[i]) begin
          o = blk_off[i];
          e = o + (64'd1 << blk_lg[i]);
          if (o < cand + sz && cand < e) begin
            // bump to the next aligned offset past this block
            cand = ((e + sz - 1) >> lg) << lg;
            hit = 1'b1;
          end
        end
      end
      if (!hit) begin
        blk_used[slot] = 1'b1;
        blk_off[slot]  = cand[30:0];
        blk_lg[slot]   = lg[4:0];
        w.ba = 32'(base_reg + cand);
        return;
      end
    end
    w.st = ST_NO_SPACE;
  endtask

  // Free: lowest valid entry whose range, at the current base, holds the address
  task automatic predict_free(input bit [31:0] a, output rsp_word_t w);
    longint unsigned s, e;
    w.st = ST_NOT_FOUND;
    w.ba = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (blk_used[i] && w.st == ST_NOT_FOUND) begin
        s = longint'(base_reg) + blk_off[i];
        e = s + (64'd1 << blk_lg[i]);
        if (a >= s && a < e) begin
          blk_used[i] = 1'b0;
          w.st = ST_OK;
        end
      end
    end
  endtask

  function automatic int live_blocks();
    int n;
    n = 0;
    foreach (blk_used[i]) n += blk_used[i];
    return n;
  endfunction

  // APB write: setup cycle, access cycle, register taken at the following edge
  task automatic write_reg(input logic idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_POOL) pool_reg = val;
    else base_reg = val[30:0];
  endtask

  task automatic drain();
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Present one command word, wait for the handshake, then book its response.
  // last lowers valid after acceptance; otherwise a random gap may follow.
  task automatic send_word(input logic cmd, input logic [31:0] arg, input bit last,
                           input bit chk, input logic [1:0] st, input logic [31:0] ba);
    rsp_word_t w;
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= cmd;
    req_ch.req_size     <= arg[30:0];
    req_ch.free_address <= arg;
    do @(posedge clk); while (!req_ch.ready);
    if (cmd == CMD_ALLOC) predict_alloc(arg[30:0], w);
    else predict_free(arg, w);
    if (chk) begin
      w.st = st;
      w.ba = ba;
    end
    pending_rsp.push_back(w);
    if (last) begin
      req_ch.valid <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
  endtask

  // Response side: random stall bursts on ready
  int rdy_left = 0;
  always @(posedge clk) begin
    if (!quiet && rdy_left > 0) begin
      rdy_left <= rdy_left - 1;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      rsp_ch.ready <= 1'b0;
      rdy_left <= $urandom_range(0, 16);
    end else begin
      rsp_ch.ready <= 1'b1;
      rdy_left <= $urandom_range(0, 16);
    end
  end

  // Compare each response word against the oldest owed word
  always @(posedge clk) begin
    rsp_word_t w;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected word status=%0d addr=%h",
                         rsp_ch.status, rsp_ch.block_address));
      end else begin
        w = pending_rsp.pop_front();
        if (rsp_ch.status !== w.st)
          report($sformatf("status %0d, want %0d", rsp_ch.status, w.st));
        if (rsp_ch.block_address !== w.ba)
          report($sformatf("block_address %h, want %h", rsp_ch.block_address, w.ba));
      end
    end
  end

  // Watchdog: too long with no handshake anywhere
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Directed rows: typed words only where obvious, the rest predicted
  stim_row_t directed [] = '{
    '{0, CMD_ALLOC, 32'd0,          1, ST_OK,        32'd0},
    '{0, CMD_ALLOC, 32'd1,          1, ST_OK,        32'd1},
    '{0, CMD_ALLOC, 32'd2,          1, ST_OK,        32'd2},
    '{0, CMD_ALLOC, 32'd3,          1, ST_OK,        32'd4},
    '{0, CMD_ALLOC, 32'h7FFF_FFFF,  1, ST_NO_SPACE,  32'd0},  // bigger than the pool
    '{0, CMD_ALLOC, 32'd1048576,    1, ST_NO_SPACE,  32'd0},  // no aligned hole
    '{0, CMD_ALLOC, 32'd524288,     1, ST_OK,        32'd524288},  // ends at pool end
    '{0, CMD_FREE,  32'd0,          1, ST_OK,        32'd0},
    '{0, CMD_FREE,  32'd0,          1, ST_NOT_FOUND, 32'd0},
    '{0, CMD_FREE,  32'hFFFF_FFFF,  1, ST_NOT_FOUND, 32'd0},
    '{0, CMD_FREE,  32'd7,          1, ST_OK,        32'd0},  // last byte of a block
    '{0, CMD_ALLOC, 32'd5,          0, ST_OK,        32'd0},
    '{0, CMD_FREE,  32'd3,          0, ST_OK,        32'd0},
    '{0, CMD_ALLOC, 32'd0,          0, ST_OK,        32'd0},
    '{1, REG_POOL,  32'd0,          0, ST_OK,        32'd0},
    '{0, CMD_ALLOC, 32'd0,          1, ST_NO_SPACE,  32'd0},  // empty pool
    '{1, REG_BASE,  32'h7FFF_FFFF,  0, ST_OK,        32'd0},
    '{0, CMD_FREE,  32'h8000_0000,  0, ST_OK,        32'd0},  // free seen at new base
    '{1, REG_POOL,  32'hFFFF_FFFF,  0, ST_OK,        32'd0},  // saturates
    '{0, CMD_ALLOC, 32'h7FFF_FFFF,  0, ST_OK,        32'd0},
    '{1, REG_POOL,  32'd1,          0, ST_OK,        32'd0},
    '{0, CMD_ALLOC, 32'd1,          0, ST_OK,        32'd0},
    '{0, CMD_ALLOC, 32'd0,          0, ST_OK,        32'd0}
  };

  // Random phases: pool, base (-1 draws one), words, percent allocates
  longint phase_pool [] = '{1048576, 64, 32'hFFFF_FFFF, 0, 32'h8000_0000, 4096, 1048576};
  longint phase_base [] = '{0, -1, 32'h7FFF_FFFF, -1, -1, -1, 0};
  int     phase_len  [] = '{350, 300, 250, 100, 130, 350, 400};
  int     phase_pct  [] = '{55, 60, 55, 50, 95, 55, 55};

  initial begin
    logic [31:0] arg;
    logic        cmd;
    int          pick, start;
    longint unsigned span;

    rst = 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    req_ch.valid <= 1'b0; req_ch.cmd <= CMD_ALLOC;
    req_ch.req_size <= '0; req_ch.free_address <= '0;
    quiet = 1'b0;
    pool_reg = POOL_RESET;
    base_reg = '0;
    foreach (blk_used[i]) blk_used[i] = 1'b0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[r]) begin
      if (directed[r].is_cfg) begin
        drain();
        write_reg(directed[r].sel, directed[r].arg);
      end else begin
        send_word(directed[r].sel, directed[r].arg,
                  r + 1 == directed.size() || directed[r + 1].is_cfg,
                  directed[r].chk, directed[r].st, directed[r].ba);
      end
    end

    foreach (phase_len[p]) begin
      // registers change only with nothing in flight
      drain();
      write_reg(REG_POOL, 32'(phase_pool[p]));
      write_reg(REG_BASE, phase_base[p] < 0 ? {1'b0, $urandom_range(0, 32'h7FFF_FFFF)}
                                            : 32'(phase_base[p]));
      quiet = (p == phase_len.size() - 1);
      for (int n = 0; n < phase_len[p]; n++) begin
        // keep the table from sticking at full outside the fill phase
        if (phase_pct[p] < 90 && live_blocks() > 20)
          cmd = ($urandom_range(0, 99) < 30) ? CMD_ALLOC : CMD_FREE;
        else
          cmd = ($urandom_range(0, 99) < phase_pct[p]) ? CMD_ALLOC : CMD_FREE;
        if (cmd == CMD_ALLOC) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7:   arg = $urandom_range(0, 8);
            8, 9, 10, 11, 12, 13:     arg = $urandom_range(0, 4096);
            14, 15, 16:               arg = $urandom_range(0, pool_reg > CAP ? CAP : pool_reg);
            default:                  arg = 32'({1'b0, $urandom} >> $urandom_range(0, 30));
          endcase
          if (phase_pct[p] >= 90 && arg > 64) arg = arg & 32'h3F;
        end else begin
          arg = $urandom;
          if ($urandom_range(0, 3) != 0 && live_blocks() != 0) begin
            // an address inside some live block
            start = $urandom_range(0, NUM_CELLS - 1);
            pick = -1;
            for (int k = 0; k < NUM_CELLS && pick < 0; k++)
              if (blk_used[(start + k) % NUM_CELLS]) pick = (start + k) % NUM_CELLS;
            span = 64'd1 << blk_lg[pick];
            arg = 32'(longint'(base_reg) + blk_off[pick] + ($urandom % span));
          end
        end
        send_word(cmd, arg, n == phase_len[p] - 1, 1'b0, ST_OK, '0);
      end
    end

    drain();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
